// ===== rtl/core/aopb_pkg.sv =====
// ----------------------------------------------------------------------------
// aopb_pkg
// Shared constants, types and the alpha reciprocal table of the alpha-over
// pixel blender.
// ----------------------------------------------------------------------------
package aopb_pkg;

  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned LANES     = 4;
  localparam int unsigned PIXEL_W   = CHAN_W * LANES;
  localparam int unsigned LANE_IX_W = 2;

  // Exact floor division by 255 for values below 2**16.
  localparam int unsigned    INV255_SHIFT = 24;
  localparam logic [16:0]    INV255       = 17'd65794;

  // Exact floor division by 255*255 for values below 2**24.
  localparam int unsigned    INV255SQ_SHIFT = 40;
  localparam logic [24:0]    INV255SQ       = 25'd16909061;

  // Exact floor division by the output alpha for values below 2**17.
  localparam int unsigned RECIP_SHIFT = 25;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
  localparam int unsigned RECIP_N     = 1 << CHAN_W;

  typedef logic [RECIP_W-1:0] recip_tab_t [RECIP_N];

  typedef enum logic {
    REG_ALPHA_PRESENT = 1'b0,
    REG_ALPHA_LANE    = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } aopb_load_t;

  // Each entry but the zero one at index 0 is the rounded-up quotient of
  // 2**RECIP_SHIFT by its index, found by restoring long division.
  function automatic recip_tab_t build_recip();
    recip_tab_t tab;
    longint     num;
    longint     rem;
    longint     quo;
    tab[0] = '0;
    for (int i = 1; i < RECIP_N; i++) begin
      num = (longint'(1) << RECIP_SHIFT) + longint'(i) - longint'(1);
      rem = 0;
      quo = 0;
      for (int b = RECIP_W - 1; b >= 0; b--) begin
        rem = (rem << 1) | ((num >> b) & longint'(1));
        quo = quo << 1;
        if (rem >= longint'(i)) begin
          rem = rem - longint'(i);
          quo = quo | longint'(1);
        end
      end
      tab[i] = RECIP_W'(quo);
    end
    return tab;
  endfunction

  localparam recip_tab_t RECIP_TAB = build_recip();

endpackage

// ===== rtl/core/aopb_lane.sv =====
// ----------------------------------------------------------------------------
// aopb_lane
// Datapath of one color channel: weighted source and backdrop terms, their
// sum, and the scaling by 255 over the output alpha.
// ----------------------------------------------------------------------------
module aopb_lane
  import aopb_pkg::*;
(
  input  logic                 clk,
  input  aopb_load_t           load,
  input  logic [CHAN_W-1:0]    cs,
  input  logic [CHAN_W-1:0]    cd,
  input  logic [CHAN_W-1:0]    sa,
  input  logic [CHAN_W-1:0]    da,
  input  logic [CHAN_W-1:0]    nsa1,
  input  logic [RECIP_W-1:0]   recip3,
  output logic [CHAN_W-1:0]    chan4
);

  logic [15:0] ps1;
  logic [15:0] pd1;
  logic [7:0]  ps2;
  logic [23:0] q2;
  logic [8:0]  mix3;
  logic [42:0] prod4;

  logic [32:0] ps_scaled;
  logic [48:0] q_scaled;
  logic [16:0] mix_x255;

  assign ps_scaled = 33'(ps1) * 33'(INV255);
  assign q_scaled  = 49'(q2) * 49'(INV255SQ);
  assign mix_x255  = {mix3, 8'd0} - 17'(mix3);

  always_ff @(posedge clk) begin
    if (load.s1) begin
      ps1 <= 16'(cs) * 16'(sa);
      pd1 <= 16'(cd) * 16'(da);
    end
    if (load.s2) begin
      ps2 <= ps_scaled[INV255_SHIFT +: 8];
      q2  <= 24'(pd1) * 24'(nsa1);
    end
    if (load.s3) begin
      mix3 <= 9'(ps2) + 9'(q_scaled[INV255SQ_SHIFT +: 8]);
    end
    if (load.s4) begin
      prod4 <= 43'(mix_x255) * 43'(recip3);
    end
  end

  assign chan4 = prod4[RECIP_SHIFT +: CHAN_W];

endmodule

// ===== rtl/core/alpha_over_pixel_blend.sv =====
// ----------------------------------------------------------------------------
// alpha_over_pixel_blend
// Source-over compositing of non-premultiplied 8-bit four-channel pixels, or pass-through of the source.
// ----------------------------------------------------------------------------
// The blender takes one source/backdrop pixel pair per clock while not stalled
// and passes it through a five-stage pipeline (alpha and channel products,
// division by 255, division by 255*255 with the reciprocal lookup of the output
// alpha, scaling by that reciprocal, and the output register). Sustained
// throughput is one pixel per cycle while result_stall is low; result_stall
// holds the output register while it is full, a full stage holds only when
// every later stage is full and held, and item_stall rises only when all five
// stages are full and result_stall is high.
// Configuration writes take effect for items transferred after the write.
module alpha_over_pixel_blend
  import aopb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [1:0]          cfg_data,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [PIXEL_W-1:0]  source_pixel,
  input  logic [PIXEL_W-1:0]  backdrop_pixel,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [PIXEL_W-1:0]  blended_pixel
);

  logic                 alpha_present;
  logic [LANE_IX_W-1:0] alpha_lane;

  logic [4:1] v;
  logic [5:1] ready;
  aopb_load_t load;

  logic [CHAN_W-1:0] sa;
  logic [CHAN_W-1:0] da;

  logic [PIXEL_W-1:0]   src1, src2, src3, src4;
  logic [LANE_IX_W-1:0] lane1, lane2, lane3, lane4, lane5;
  logic                 pres1, pres2, pres3, pres4, pres5;
  logic [CHAN_W-1:0]    sa1, nsa1;
  logic [15:0]          t1;
  logic [CHAN_W-1:0]    oa2, oa3, oa4;
  logic [RECIP_W-1:0]   recip3;

  logic [32:0]          t_scaled;
  logic [CHAN_W-1:0]    chan4 [LANES];
  logic [PIXEL_W-1:0]   blended_next;
  logic                 alpha_clear;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_present <= 1'b1;
      alpha_lane    <= 2'd3;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_ALPHA_PRESENT: alpha_present <= cfg_data[0];
        REG_ALPHA_LANE:    alpha_lane    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ready[5] = !result_valid || !result_stall;
  assign ready[4] = !v[4] || ready[5];
  assign ready[3] = !v[3] || ready[4];
  assign ready[2] = !v[2] || ready[3];
  assign ready[1] = !v[1] || ready[2];
  assign item_stall = !ready[1];

  assign load = '{s1: ready[1], s2: ready[2], s3: ready[3], s4: ready[4]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v            <= '0;
      result_valid <= 1'b0;
    end else begin
      if (ready[1]) v[1] <= item_valid;
      if (ready[2]) v[2] <= v[1];
      if (ready[3]) v[3] <= v[2];
      if (ready[4]) v[4] <= v[3];
      if (ready[5]) result_valid <= v[4];
    end
  end

  assign sa = source_pixel[{alpha_lane, 3'b000} +: CHAN_W];
  assign da = backdrop_pixel[{alpha_lane, 3'b000} +: CHAN_W];
  assign t_scaled = 33'(t1) * 33'(INV255);

  always_ff @(posedge clk) begin
    if (load.s1) begin
      src1  <= source_pixel;
      lane1 <= alpha_lane;
      pres1 <= alpha_present;
      sa1   <= sa;
      nsa1  <= 8'd255 - sa;
      t1    <= 16'(da) * 16'(8'd255 - sa);
    end
    if (load.s2) begin
      src2  <= src1;
      lane2 <= lane1;
      pres2 <= pres1;
      oa2   <= sa1 + t_scaled[INV255_SHIFT +: CHAN_W];
    end
    if (load.s3) begin
      src3   <= src2;
      lane3  <= lane2;
      pres3  <= pres2;
      oa3    <= oa2;
      recip3 <= RECIP_TAB[oa2];
    end
    if (load.s4) begin
      src4  <= src3;
      lane4 <= lane3;
      pres4 <= pres3;
      oa4   <= oa3;
    end
    if (ready[5]) begin
      blended_pixel <= blended_next;
      lane5         <= lane4;
      pres5         <= pres4;
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    aopb_lane u_lane (
      .clk    (clk),
      .load   (load),
      .cs     (source_pixel[k*CHAN_W +: CHAN_W]),
      .cd     (backdrop_pixel[k*CHAN_W +: CHAN_W]),
      .sa     (sa),
      .da     (da),
      .nsa1   (nsa1),
      .recip3 (recip3),
      .chan4  (chan4[k])
    );
  end

  // A zero output alpha has a zero reciprocal, so in blending mode every channel comes out zero.
  always_comb begin
    blended_next = '0;
    for (int k = 0; k < LANES; k++) begin
      if (LANE_IX_W'(k) == lane4) begin
        blended_next[k*CHAN_W +: CHAN_W] = oa4;
      end else begin
        blended_next[k*CHAN_W +: CHAN_W] = chan4[k];
      end
    end
    if (!pres4) begin
      blended_next = src4;
    end
  end

  always_comb begin
    alpha_clear = 1'b1;
    if (blended_pixel[{lane5, 3'b000} +: CHAN_W] == '0 && blended_pixel != '0) begin
      alpha_clear = 1'b0;
    end
  end

  assert property (@(posedge clk) rst |=> !result_valid && v == '0)
    else $error("pipeline not empty after reset");

  assert property (@(posedge clk) disable iff (rst) item_stall |-> v[1])
    else $error("input stalled while the first stage is empty");

  assert property (@(posedge clk) disable iff (rst) v[4] && ready[5] |=> result_valid)
    else $error("item lost between the last stage and the output");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && pres5 |-> alpha_clear)
    else $error("zero output alpha left a channel set");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the alpha-over pixel blender.
// ----------------------------------------------------------------------------
// Pixel pairs are streamed into the blender, and every transfer is predicted
// by a behavioral source-over model that holds its own copy of the alpha
// enable and alpha lane. Each result is compared with the oldest prediction.
// Directed corner pixels come first, then the other alpha lanes and the
// pass-through mode. A long output hold-off follows, then randomized phases
// under changing register settings. Both sides idle at random until a final
// full-rate stretch.
// ----------------------------------------------------------------------------
module tb
  import aopb_pkg::*;
;

  localparam int unsigned PIPE_DEPTH  = 5;
  localparam int unsigned HOLD_CYCLES = 40;
  localparam int unsigned QUIET_LIMIT = 2000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write;
  cfg_reg_t           cfg_index;
  logic [1:0]         cfg_data;
  logic               item_valid;
  logic               item_stall;
  logic [PIXEL_W-1:0] source_pixel;
  logic [PIXEL_W-1:0] backdrop_pixel;
  logic               result_valid;
  logic               result_stall;
  logic [PIXEL_W-1:0] blended_pixel;

  logic               model_alpha_on;
  logic [1:0]         model_alpha_lane;
  logic [PIXEL_W-1:0] expected_pixels [$];

  bit                 tx_idle_on;
  bit                 rx_idle_on;
  bit                 hold_request;
  int unsigned        error_count;
  int unsigned        pixels_sent;
  int unsigned        pixels_checked;
  int unsigned        reg_writes;
  int unsigned        quiet_cycles;

  alpha_over_pixel_blend u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .source_pixel   (source_pixel),
    .backdrop_pixel (backdrop_pixel),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .blended_pixel  (blended_pixel)
  );

  always #1 clk = ~clk;

  function automatic logic [PIXEL_W-1:0] blend_expect(input logic [PIXEL_W-1:0] src,
                                                      input logic [PIXEL_W-1:0] bkg);
    int unsigned        sa;
    int unsigned        da;
    int unsigned        oa;
    int unsigned        mix;
    int unsigned        chan;
    logic [PIXEL_W-1:0] px;
    if (!model_alpha_on) return src;
    sa = src[8*model_alpha_lane +: 8];
    da = bkg[8*model_alpha_lane +: 8];
    oa = sa + (da * (255 - sa)) / 255;
    if (oa == 0) return '0;
    for (int k = 0; k < LANES; k++) begin
      mix  = (src[8*k +: 8] * sa) / 255 + (bkg[8*k +: 8] * da * (255 - sa)) / (255 * 255);
      chan = (mix * 255) / oa;
      if (k == model_alpha_lane) chan = oa;
      px[8*k +: 8] = chan[7:0];
    end
    return px;
  endfunction

  function automatic logic [PIXEL_W-1:0] random_pixel(input logic [1:0] lane);
    logic [PIXEL_W-1:0] px;
    px = $urandom;
    case ($urandom_range(0, 5))
      0: px[8*lane +: 8] = 8'h00;
      1: px[8*lane +: 8] = 8'hFF;
      default: ;
    endcase
    return px;
  endfunction

  task automatic send_pixel(input logic [PIXEL_W-1:0] src, input logic [PIXEL_W-1:0] bkg);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    item_valid     <= 1'b1;
    source_pixel   <= src;
    backdrop_pixel <= bkg;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    expected_pixels.push_back(blend_expect(src, bkg));
    pixels_sent++;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [1:0] val);
    item_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 1) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_ALPHA_PRESENT: model_alpha_on   = val[0];
      REG_ALPHA_LANE:    model_alpha_lane = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic test_blend_corners();
    send_pixel(32'h0000_0000, 32'h0000_0000);
    send_pixel(32'h00FF_FFFF, 32'h00FF_FFFF);
    send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
    send_pixel(32'h0012_3456, 32'hFF89_ABCD);
    send_pixel(32'h80FF_0000, 32'h8000_00FF);
    send_pixel(32'h01FF_FFFF, 32'h00FF_FFFF);
    send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pixel(32'hAA55_AA55, 32'h55AA_55AA);
    send_pixel(32'h55AA_55AA, 32'hAA55_AA55);
  endtask

  task automatic test_alpha_lanes();
    for (int lane = 0; lane < 3; lane++) begin
      write_reg(REG_ALPHA_LANE, 2'(lane));
      send_pixel(32'hFFFF_FFFF ^ (32'hFF << (8 * lane)), 32'h1234_5678);
      send_pixel(32'h0000_0000, 32'h0000_0000);
      send_pixel(32'h7F7F_7F7F, 32'hC0C0_C0C0);
    end
    write_reg(REG_ALPHA_LANE, 2'd3);
  endtask

  task automatic test_pass_through();
    write_reg(REG_ALPHA_PRESENT, 2'b00);
    send_pixel(32'h0000_0000, 32'hFFFF_FFFF);
    send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
    send_pixel(32'h00AB_CDEF, 32'h1111_1111);
    write_reg(REG_ALPHA_PRESENT, 2'b01);
  endtask

  task automatic test_output_hold_off();
    hold_request = 1'b1;
    for (int i = 0; i < 30; i++) begin
      send_pixel(random_pixel(model_alpha_lane), random_pixel(model_alpha_lane));
    end
  endtask

  task automatic test_random_phases(input int unsigned phases, input int unsigned per_phase);
    for (int p = 0; p < phases; p++) begin
      write_reg(REG_ALPHA_LANE, 2'($urandom_range(0, 3)));
      write_reg(REG_ALPHA_PRESENT,
                ($urandom_range(0, 3) == 0) ? 2'b10 : 2'($urandom_range(0, 1)) | 2'b01);
      for (int i = 0; i < per_phase; i++) begin
        send_pixel(random_pixel(model_alpha_lane), random_pixel(model_alpha_lane));
      end
    end
  endtask

  initial begin
    cfg_write        = 1'b0;
    cfg_index        = REG_ALPHA_PRESENT;
    cfg_data         = 2'b00;
    item_valid       = 1'b0;
    source_pixel     = '0;
    backdrop_pixel   = '0;
    model_alpha_on   = 1'b1;
    model_alpha_lane = 2'd3;
    tx_idle_on       = 1'b1;
    rx_idle_on       = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_blend_corners();
    test_alpha_lanes();
    test_pass_through();
    test_output_hold_off();
    test_random_phases(8, 110);

    write_reg(REG_ALPHA_LANE, 2'd0);
    write_reg(REG_ALPHA_PRESENT, 2'b01);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_phases(1, 80);

    item_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH * 2) @(posedge clk);
    $display("Checked %0d of %0d pixel transfers across %0d register writes.",
             pixels_checked, pixels_sent, reg_writes);
    $display("Run covered corner alphas, every alpha lane, pass-through and output back-pressure.");
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        result_stall <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("blended_pixel arrived with no transfer pending: got %h", blended_pixel);
        error_count++;
      end else begin
        if (blended_pixel !== expected_pixels[0]) begin
          $error("blended_pixel mismatch: expected %h, got %h",
                 expected_pixels[0], blended_pixel);
          error_count++;
        end
        void'(expected_pixels.pop_front());
        pixels_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
